[rtl/hha_pkg.sv]
// Shared types and constants of the hill heightmap accumulate unit.
package hha_pkg;

  // Coordinate width: a center of 8 bits plus a radius of 8 bits reaches 510.
  localparam int COORD_W = 9;
  // Field widths of the command and result items.
  localparam int POS_W = 8;
  localparam int HEIGHT_W = 32;
  localparam int CFG_W = 9;

  // Default storage geometry.
  localparam int GRID_W_DEFAULT = 256;
  localparam int GRID_H_DEFAULT = 256;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Command codes.
  typedef enum logic {
    CMD_HILL = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_WIDTH_USED  = 1'b0,
    REG_HEIGHT_USED = 1'b1
  } reg_index_t;

  // One command item.
  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] radius;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height_value;
    logic                saturated;
  } result_t;

endpackage

[rtl/hha_grid_ram.sv]
// Height grid storage: one write port and one registered read port.
module hha_grid_ram #(
  parameter int DEPTH  = hha_pkg::GRID_W_DEFAULT * hha_pkg::GRID_H_DEFAULT,
  parameter int DATA_W = hha_pkg::HEIGHT_W,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hill_heightmap_accumulate_unit.sv]
// Top level of the hill heightmap accumulate unit.
//
// Commands arrive on item with start; a command transfers at a rising edge
// where start is high and busy is low. Each command gives one result on
// result, marked by done for exactly one cycle; the receiver always takes it.
// A read command gives the stored height of cell (pos_x, pos_y), or zero
// outside the region in use; its result shows in ST_DONE, after ST_READ.
// A hill command adds radius^2 - d^2 to every cell in use strictly inside
// the circle, saturating, and reports whether any cell ended at the maximum.
// The grid is scanned one row of the clipped bounding box at a time: a setup
// state (ST_ROW) for the row, then one read-modify-write cell per cycle through
// the single memory port pair; an empty box goes from ST_SETUP to ST_DONE.
// Configuration writes (width_used, height_used) take effect at once; the user
// must make them while the unit is idle, and the unit does not enforce this.
// After reset the unit sweeps the grid to zero, one word a cycle, with busy
// high throughout; configuration writes are still taken.
module hill_heightmap_accumulate_unit #(
  parameter int GRID_W = hha_pkg::GRID_W_DEFAULT,
  parameter int GRID_H = hha_pkg::GRID_H_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [hha_pkg::CFG_W-1:0] cfg_data,
  input  logic                      start,
  input  hha_pkg::item_t            item,
  output logic                      busy,
  output logic                      done,
  output hha_pkg::result_t          result
);

  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = hha_pkg::COORD_W;
  localparam int PW     = hha_pkg::POS_W;
  localparam int HW     = hha_pkg::HEIGHT_W;
  localparam int SQ_W   = 2 * PW;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_SETUP = 9'b000000100,
    ST_BASE  = 9'b000001000,
    ST_ROW   = 9'b000010000,
    ST_SCAN  = 9'b000100000,
    ST_DRAIN = 9'b001000000,
    ST_READ  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [hha_pkg::CFG_W-1:0] width_used, height_used;

  // Latched command.
  hha_pkg::cmd_t cmd;
  logic [CW-1:0] cx, cy;
  logic [PW-1:0] r;

  // Scan bounds and counters.
  logic [CW-1:0]     x0, x1, y1, x, y;
  logic [SQ_W-1:0]   r2, dy2;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] clr_addr;

  // Read-modify-write stage.
  logic              p1_valid;
  logic [ADDR_W-1:0] p1_addr;
  logic [SQ_W-1:0]   p1_inc;
  logic              sat_acc;
  logic              rd_inside;

  // Memory ports.
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [HW-1:0]     wr_data, rd_data;

  // Region in use, clamped to the storage size.
  logic [CW-1:0] cols, rows;
  assign cols = (32'(width_used) < GRID_W) ? CW'(width_used) : CW'(GRID_W);
  assign rows = (32'(height_used) < GRID_H) ? CW'(height_used) : CW'(GRID_H);

  // Clipped bounding box of the hill.
  logic [CW-1:0] sx0, sy0, sx1, sy1, sum_x, sum_y;
  assign sum_x = cx + CW'(r);
  assign sum_y = cy + CW'(r);
  assign sx0 = (cx > CW'(r)) ? cx - CW'(r) : '0;
  assign sy0 = (cy > CW'(r)) ? cy - CW'(r) : '0;
  assign sx1 = (sum_x < cols) ? sum_x : cols;
  assign sy1 = (sum_y < rows) ? sum_y : rows;

  // Distance of the current cell from the center.
  logic [CW-1:0]   dx_full, dy_full;
  logic [SQ_W-1:0] dx2;
  logic [SQ_W:0]   d2;
  logic            hit, row_last, col_last;
  assign dx_full  = (x > cx) ? x - cx : cx - x;
  assign dy_full  = (y > cy) ? y - cy : cy - y;
  assign dx2      = dx_full[PW-1:0] * dx_full[PW-1:0];
  assign d2       = {1'b0, dx2} + {1'b0, dy2};
  assign hit      = d2 < {1'b0, r2};
  assign col_last = (x + 1'b1) == x1;
  assign row_last = (y + 1'b1) == y1;

  // Saturating add of the hill increment to the stored height.
  logic [HW:0] sum;
  logic        sum_sat;
  assign sum     = {1'b0, rd_data} + (HW + 1)'(p1_inc);
  assign sum_sat = sum >= {1'b0, hha_pkg::HEIGHT_MAX};

  // Memory write: clearing sweep, or write-back of the modify stage.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p1_addr;
    wr_data = sum_sat ? hha_pkg::HEIGHT_MAX : sum[HW-1:0];
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (p1_valid) begin
      wr_en = 1'b1;
    end
  end

  // Memory read: a cell of the scan, or the cell of a read command.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_base + ADDR_W'(x);
    if (state == ST_SCAN) begin
      rd_en = hit;
    end else if (state == ST_READ) begin
      rd_en   = (cx < cols) && (cy < rows);
      rd_addr = ADDR_W'(32'(cy) * GRID_W + 32'(cx));
    end
  end

  hha_grid_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (HW),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (item.cmd == hha_pkg::CMD_READ) ? ST_READ : ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ((sx0 >= sx1) || (sy0 >= sy1)) ? ST_DONE : ST_BASE;
      end
      ST_BASE:  state_next = ST_ROW;
      ST_ROW:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (col_last) state_next = row_last ? ST_DRAIN : ST_ROW;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_READ:  state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      p1_valid    <= 1'b0;
      width_used  <= hha_pkg::CFG_RESET;
      height_used <= hha_pkg::CFG_RESET;
    end else begin
      state    <= state_next;
      p1_valid <= (state == ST_SCAN) && hit;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_write) begin
        unique case (hha_pkg::reg_index_t'(cfg_index))
          hha_pkg::REG_WIDTH_USED:  width_used  <= cfg_data;
          hha_pkg::REG_HEIGHT_USED: height_used <= cfg_data;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Command transfer.
    if ((state == ST_IDLE) && start) begin
      cmd     <= item.cmd;
      cx      <= CW'(item.pos_x);
      cy      <= CW'(item.pos_y);
      r       <= item.radius;
      sat_acc <= 1'b0;
    end
    // Bounds of the scan.
    if (state == ST_SETUP) begin
      x0 <= sx0;
      x1 <= sx1;
      y  <= sy0;
      y1 <= sy1;
      r2 <= r * r;
    end
    // First row address.
    if (state == ST_BASE) begin
      row_base <= ADDR_W'(32'(y) * GRID_W);
    end
    // Per-row setup.
    if (state == ST_ROW) begin
      dy2 <= dy_full[PW-1:0] * dy_full[PW-1:0];
      x   <= x0;
    end
    // One cell per cycle along the row.
    if (state == ST_SCAN) begin
      p1_addr <= rd_addr;
      p1_inc  <= r2 - d2[SQ_W-1:0];
      x       <= x + 1'b1;
      if (col_last && !row_last) begin
        y        <= y + 1'b1;
        row_base <= row_base + ADDR_W'(GRID_W);
      end
    end
    // Saturation flag collected at write-back.
    if (p1_valid && sum_sat) sat_acc <= 1'b1;
    if (state == ST_READ) rd_inside <= rd_en;
  end

  // Result drive.
  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  always_comb begin
    result.height_value = '0;
    result.saturated    = 1'b0;
    if (cmd == hha_pkg::CMD_READ) begin
      result.height_value = rd_inside ? rd_data : '0;
    end else begin
      result.saturated = sat_acc;
    end
  end

endmodule

[tb/hha_result_checker.sv]
// Checker for the hill heightmap accumulate unit: predicts each result and compares it.
`timescale 1ns / 100ps

module hha_result_checker #(
  parameter int GRID_W = hha_pkg::GRID_W_DEFAULT,
  parameter int GRID_H = hha_pkg::GRID_H_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [hha_pkg::CFG_W-1:0] cfg_data,
  input  logic                      start,
  input  hha_pkg::item_t            item,
  input  logic                      busy,
  input  logic                      done,
  input  hha_pkg::result_t          result,
  output int                        fail_count,
  output int                        pending_results
);

  // Shadow copy of the height grid and the region registers.
  logic [hha_pkg::HEIGHT_W-1:0] grid_heights [GRID_W*GRID_H];
  logic [hha_pkg::CFG_W-1:0]    cols_reg;
  logic [hha_pkg::CFG_W-1:0]    rows_reg;
  hha_pkg::result_t             expected_results[$];
  int                           mismatches = 0;

  assign fail_count = mismatches;

  // The region in use never reaches past the storage.
  function automatic int cols_in_use();
    return (cols_reg < GRID_W) ? int'(cols_reg) : GRID_W;
  endfunction

  function automatic int rows_in_use();
    return (rows_reg < GRID_H) ? int'(rows_reg) : GRID_H;
  endfunction

  // Adds one hill to the shadow grid and returns whether any cell saturated.
  function automatic logic raise_hill(int cx, int cy, int r);
    int          x_lo;
    int          x_hi;
    int          y_lo;
    int          y_hi;
    int          r2;
    int          d2;
    int          idx;
    logic [63:0] sum;
    logic        sat;
    x_lo = (cx > r) ? cx - r : 0;
    y_lo = (cy > r) ? cy - r : 0;
    x_hi = (cx + r < cols_in_use()) ? cx + r : cols_in_use();
    y_hi = (cy + r < rows_in_use()) ? cy + r : rows_in_use();
    r2 = r * r;
    sat = 1'b0;
    for (int y = y_lo; y < y_hi; y++) begin
      for (int x = x_lo; x < x_hi; x++) begin
        d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
        if (d2 < r2) begin
          idx = y * GRID_W + x;
          sum = {32'd0, grid_heights[idx]} + 64'(r2 - d2);
          if (sum >= {32'd0, hha_pkg::HEIGHT_MAX}) begin
            sum = {32'd0, hha_pkg::HEIGHT_MAX};
            sat = 1'b1;
          end
          grid_heights[idx] = sum[hha_pkg::HEIGHT_W-1:0];
        end
      end
    end
    return sat;
  endfunction

  // Cells outside the region in use read as zero.
  function automatic logic [hha_pkg::HEIGHT_W-1:0] cell_height(int x, int y);
    if (x >= cols_in_use() || y >= rows_in_use()) return '0;
    return grid_heights[y * GRID_W + x];
  endfunction

  function automatic void note_mismatch(string what, hha_pkg::result_t want,
                                        hha_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected height %h sat %b, got height %h sat %b", $realtime, what,
               want.height_value, want.saturated, got.height_value, got.saturated);
    end
  endfunction

  // Results are retired before new commands are predicted in the same cycle.
  always @(posedge clk) begin
    hha_pkg::result_t want;
    if (rst) begin
      foreach (grid_heights[i]) grid_heights[i] = '0;
      cols_reg = hha_pkg::CFG_RESET;
      rows_reg = hha_pkg::CFG_RESET;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing expected", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (result.height_value !== want.height_value) begin
            note_mismatch("height_value differs", want, result);
          end
          if (result.saturated !== want.saturated) begin
            note_mismatch("saturated differs", want, result);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == hha_pkg::REG_WIDTH_USED) begin
          cols_reg = cfg_data;
        end else begin
          rows_reg = cfg_data;
        end
      end
      if (start && !busy) begin
        want = '0;
        if (item.cmd == hha_pkg::CMD_HILL) begin
          want.saturated = raise_hill(item.pos_x, item.pos_y, item.radius);
        end else begin
          want.height_value = cell_height(item.pos_x, item.pos_y);
        end
        expected_results.push_back(want);
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

[tb/tb.sv]
// Testbench top of the hill heightmap accumulate unit: clock, reset, commands and verdict.
`timescale 1ns / 100ps

module tb;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [hha_pkg::CFG_W-1:0] cfg_data;
  logic                      start;
  hha_pkg::item_t            item;
  logic                      busy;
  logic                      done;
  hha_pkg::result_t          result;
  int                        fail_count;
  int                        pending_results;

  // Region in use as the stimulus sees it, and the most recent hill.
  int cols_now;
  int rows_now;
  int last_cx;
  int last_cy;
  int last_r;

  hill_heightmap_accumulate_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  hha_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .item            (item),
    .busy            (busy),
    .done            (done),
    .result          (result),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Holds start high until the command transfers; start stays high afterwards.
  task automatic send_item(input hha_pkg::item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic send_hill(input int x, input int y, input int r);
    hha_pkg::item_t it;
    it.cmd = hha_pkg::CMD_HILL;
    it.pos_x = hha_pkg::POS_W'(x);
    it.pos_y = hha_pkg::POS_W'(y);
    it.radius = hha_pkg::POS_W'(r);
    last_cx = x;
    last_cy = y;
    last_r = r;
    send_item(it);
  endtask

  // The radius field of a read carries random bits; the unit ignores it.
  task automatic send_read(input int x, input int y);
    hha_pkg::item_t it;
    it.cmd = hha_pkg::CMD_READ;
    it.pos_x = hha_pkg::POS_W'(x);
    it.pos_y = hha_pkg::POS_W'(y);
    it.radius = hha_pkg::POS_W'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Writes both region registers once the unit has nothing outstanding.
  task automatic set_region(input int w, input int h);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= hha_pkg::REG_WIDTH_USED;
    cfg_data <= hha_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= hha_pkg::REG_HEIGHT_USED;
    cfg_data <= hha_pkg::CFG_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    cols_now = (w > hha_pkg::GRID_W_DEFAULT) ? hha_pkg::GRID_W_DEFAULT : w;
    rows_now = (h > hha_pkg::GRID_H_DEFAULT) ? hha_pkg::GRID_H_DEFAULT : h;
  endtask

  initial begin
    int pick;
    int radius;
    int cx;
    int cy;
    int span;
    int big_hills_left;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= hha_pkg::REG_WIDTH_USED;
    cfg_data <= '0;
    start <= 1'b0;
    item <= '0;
    big_hills_left = 3;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, both commands and the region corner cases.
    set_region(256, 256);
    send_read(0, 0);
    send_hill(5, 5, 0);
    send_read(5, 5);
    send_hill(10, 10, 1);
    send_read(10, 10);
    send_hill(0, 0, 3);
    send_read(0, 0);
    send_read(2, 1);
    send_hill(255, 255, 255);
    send_read(255, 255);
    send_read(0, 0);
    send_read(128, 128);
    send_hill(64, 64, 128);
    send_read(64, 64);
    send_read(255, 0);
    // Small region with a hill centered outside it.
    set_region(20, 12);
    send_hill(30, 5, 15);
    send_read(19, 5);
    send_read(25, 5);
    send_read(10, 10);
    // Empty region: hills change nothing and reads give zero.
    set_region(0, 256);
    send_hill(3, 3, 5);
    send_read(3, 3);
    // Registers above the storage size clamp, and old cells come back into use.
    set_region(511, 300);
    send_read(25, 5);
    send_read(3, 3);
    send_hill(250, 250, 10);
    send_read(255, 255);

    // Random part: hills followed mostly by reads around them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_region(256, 256);
        1: set_region($urandom_range(1, 256), $urandom_range(1, 256));
        2: set_region(256, 1);
        3: set_region($urandom_range(0, 511), $urandom_range(0, 511));
        default: set_region(256, 256);
      endcase
      for (int n = 0; n < 23; n++) begin
        // The last phase runs without idle cycles.
        if (phase < 4 && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));
        if (phase == 0 && n == 14) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          pick = $urandom_range(0, 99);
          if (big_hills_left > 0 && pick < 3) begin
            radius = $urandom_range(100, 255);
            big_hills_left--;
          end else if (pick < 15) begin
            radius = $urandom_range(13, 40);
          end else begin
            radius = $urandom_range(0, 12);
          end
          if (cols_now > 0 && rows_now > 0 && $urandom_range(0, 3) != 0) begin
            cx = $urandom_range(0, (cols_now + 3 > 255) ? 255 : cols_now + 3);
            cy = $urandom_range(0, (rows_now + 3 > 255) ? 255 : rows_now + 3);
          end else begin
            cx = $urandom_range(0, 255);
            cy = $urandom_range(0, 255);
          end
          send_hill(cx, cy, radius);
        end else if (pick < 90) begin
          span = (last_r > 0) ? last_r : 1;
          cx = last_cx + int'($urandom_range(0, 2 * span)) - span;
          cy = last_cy + int'($urandom_range(0, 2 * span)) - span;
          cx = (cx < 0) ? 0 : ((cx > 255) ? 255 : cx);
          cy = (cy < 0) ? 0 : ((cy > 255) ? 255 : cy);
          send_read(cx, cy);
        end else begin
          send_read($urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
    end

    // Let the last results arrive, then watch for stray ones.
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
